### rtl/core/lpfr_pkg.sv
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types and constants of the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 17;
  localparam int TMO_W   = 16;
  localparam int HDR_W   = 24;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // largest payload length the receiver ever opens
  localparam int FRAME_LIMIT = 65536;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(FRAME_LIMIT);

  localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(4096);
  localparam logic [TMO_W-1:0] TIMEOUT_RST = TMO_W'(2000);

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] TYPE_OPEN    = 2'd0;
  localparam logic [1:0] TYPE_UNTYPED = 2'd1;
  localparam logic [1:0] TYPE_TYPED   = 2'd2;

  localparam logic [1:0] FTYPE_UNTYPED = 2'd1;

  localparam logic [BYTE_W-1:0] OPEN_BRACE  = 8'h7B;
  localparam logic [BYTE_W-1:0] TYPE_BYTE_2 = 8'd2;
  localparam logic [BYTE_W-1:0] TYPE_BYTE_1 = 8'd1;
  localparam logic [BYTE_W-1:0] TYPE_BYTE_3 = 8'd3;

  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic [1:0]        frm_type;
    logic              typed;
    logic              last;
    logic              abort;
  } out_word_t;

endpackage

### rtl/core/lpfr_if.sv
// ----------------------------------------------------------------------------
// lpfr_in_if / lpfr_out_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface lpfr_in_if import lpfr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lpfr_out_if import lpfr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/length_prefixed_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_core
// Deframes a byte stream with 4-byte big-endian length headers, classifies
// the frame type and streams payload bytes out; aborts stalled frames.
// ----------------------------------------------------------------------------
// One word (a byte or a tick) is taken every cycle while in_ch.ready is
// high; its results enter a 4-word output queue at the next clock edge, so
// a result is in the queue in the cycle after its word is accepted. A word
// yields at most two results (only when a held first byte is released), and
// in_ch.ready drops while fewer than two queue slots are free, so throughput
// is one word per cycle as long as the sink drains one word per cycle.
module length_prefixed_frame_receiver_core import lpfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lpfr_in_if.sink               in_ch,
  lpfr_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [ADDR_W-1:0]     cfg_paddr,
  input  logic [DATA_W-1:0]     cfg_pwdata,
  output logic [DATA_W-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  // configuration
  logic [LEN_W-1:0] max_len_r;
  logic [TMO_W-1:0] timeout_r;
  logic             cfg_wr;

  // parser state
  logic [HDR_W-1:0]  hdr_r,      hdr_nxt;
  logic [1:0]        hdr_cnt_r,  hdr_cnt_nxt;
  logic              in_pay_r,   in_pay_nxt;
  logic [LEN_W-1:0]  exp_len_r,  exp_len_nxt;
  logic [LEN_W-1:0]  rcv_cnt_r,  rcv_cnt_nxt;
  logic [BYTE_W-1:0] held_r,     held_nxt;
  logic [1:0]        tdec_r,     tdec_nxt;
  logic [TMO_W-1:0]  idle_r,     idle_nxt;

  // output queue
  out_word_t         fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              in_fire, out_fire, pending, last, hdr_bad, clear;
  logic [1:0]        n_push;
  out_word_t         res0, res1;
  logic [LEN_W-1:0]  lim, rcv_inc;
  logic [31:0]       hdr_len;
  logic [BYTE_W-1:0] b;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_MAX_LEN: max_len_r <= cfg_pwdata[LEN_W-1:0];
        REG_TIMEOUT: timeout_r <= cfg_pwdata[TMO_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MAX_LEN: cfg_prdata = DATA_W'(max_len_r);
      REG_TIMEOUT: cfg_prdata = DATA_W'(timeout_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // ---------------- parser ----------------
  assign in_ch.ready = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign b           = in_ch.data.rx_byte;
  assign pending     = (hdr_cnt_r != 2'd0) | in_pay_r;
  assign lim         = (max_len_r < LEN_CAP) ? max_len_r : LEN_CAP;
  assign hdr_len     = {hdr_r, b};
  assign hdr_bad     = (hdr_len == 32'd0) | (|hdr_len[31:LEN_W]) |
                       (hdr_len[LEN_W-1:0] > lim);
  assign rcv_inc     = rcv_cnt_r + LEN_W'(1);
  assign last        = (rcv_inc >= exp_len_r);

  always_comb begin
    hdr_nxt     = hdr_r;
    hdr_cnt_nxt = hdr_cnt_r;
    in_pay_nxt  = in_pay_r;
    exp_len_nxt = exp_len_r;
    rcv_cnt_nxt = rcv_cnt_r;
    held_nxt    = held_r;
    tdec_nxt    = tdec_r;
    idle_nxt    = idle_r;
    clear       = 1'b0;
    n_push      = 2'd0;
    res0        = '{payload_byte: b, frm_type: FTYPE_UNTYPED, typed: 1'b0,
                    last: last, abort: 1'b0};
    res1        = res0;
    if (in_fire) begin
      if (in_ch.data.kind == KIND_TICK) begin
        if (pending) begin
          if (idle_r >= timeout_r) begin
            clear = 1'b1;
            if (in_pay_r) begin
              res0   = '{payload_byte: '0, frm_type: FTYPE_UNTYPED, typed: 1'b0,
                         last: 1'b0, abort: 1'b1};
              n_push = 2'd1;
            end
          end else begin
            idle_nxt = idle_r + TMO_W'(1);
          end
        end
      end else if (in_pay_r) begin
        rcv_cnt_nxt = rcv_inc;
        idle_nxt    = '0;
        if (rcv_cnt_r == '0) begin
          if (b == TYPE_BYTE_2) begin
            held_nxt = b;
            tdec_nxt = TYPE_TYPED;
          end else if ((b == TYPE_BYTE_1 || b == TYPE_BYTE_3) &&
                       exp_len_r > LEN_W'(1)) begin
            held_nxt = b;
            tdec_nxt = TYPE_OPEN;
          end else begin
            tdec_nxt = TYPE_UNTYPED;
            n_push   = 2'd1;
          end
        end else if (tdec_r == TYPE_OPEN) begin
          if (b == OPEN_BRACE) begin
            tdec_nxt      = TYPE_TYPED;
            res0.frm_type = held_r[1:0];
            res0.typed    = 1'b1;
            n_push        = 2'd1;
          end else begin
            tdec_nxt          = TYPE_UNTYPED;
            res0.payload_byte = held_r;
            res0.last         = 1'b0;
            res1.payload_byte = b;
            n_push            = 2'd2;
          end
        end else if (tdec_r == TYPE_TYPED) begin
          res0.frm_type = held_r[1:0];
          res0.typed    = 1'b1;
          n_push        = 2'd1;
        end else begin
          n_push = 2'd1;
        end
        if (last) begin
          clear = 1'b1;
        end
      end else begin
        idle_nxt = '0;
        if (hdr_cnt_r != 2'd3) begin
          hdr_nxt     = {hdr_r[HDR_W-BYTE_W-1:0], b};
          hdr_cnt_nxt = hdr_cnt_r + 2'd1;
        end else if (hdr_bad) begin
          hdr_nxt = hdr_len[HDR_W-1:0];
        end else begin
          hdr_nxt     = '0;
          hdr_cnt_nxt = 2'd0;
          in_pay_nxt  = 1'b1;
          exp_len_nxt = hdr_len[LEN_W-1:0];
          rcv_cnt_nxt = '0;
          held_nxt    = '0;
          tdec_nxt    = TYPE_OPEN;
        end
      end
    end
    if (clear) begin
      hdr_nxt     = '0;
      hdr_cnt_nxt = 2'd0;
      in_pay_nxt  = 1'b0;
      exp_len_nxt = '0;
      rcv_cnt_nxt = '0;
      held_nxt    = '0;
      tdec_nxt    = TYPE_OPEN;
      idle_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r     <= '0;
      hdr_cnt_r <= 2'd0;
      in_pay_r  <= 1'b0;
      exp_len_r <= '0;
      rcv_cnt_r <= '0;
      held_r    <= '0;
      tdec_r    <= TYPE_OPEN;
      idle_r    <= '0;
    end else begin
      hdr_r     <= hdr_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      in_pay_r  <= in_pay_nxt;
      exp_len_r <= exp_len_nxt;
      rcv_cnt_r <= rcv_cnt_nxt;
      held_r    <= held_nxt;
      tdec_r    <= tdec_nxt;
      idle_r    <= idle_nxt;
    end
  end

  // ---------------- output queue ----------------
  assign out_ch.valid = (cnt_r != '0);
  assign out_ch.data  = fifo_r[rd_ptr_r];
  assign out_fire     = out_ch.valid & out_ch.ready;
  assign wr_ptr_p1    = wr_ptr_r + PTR_W'(1);
  assign wr_ptr_nxt   = wr_ptr_r + PTR_W'(n_push);
  assign rd_ptr_nxt   = rd_ptr_r + PTR_W'(out_fire);
  assign cnt_nxt      = cnt_r + CNT_W'(n_push) - CNT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_r[wr_ptr_p1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("output queue overfilled");

  a_hdr_idle_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    in_pay_r |-> hdr_cnt_r == 2'd0)
    else $error("header bytes pending during payload");

  a_abort_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.abort |->
      out_ch.data.payload_byte == '0 && !out_ch.data.last && !out_ch.data.typed)
    else $error("malformed abort word");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    n_push != 2'd0 |-> in_fire)
    else $error("result pushed without accepted word");
`endif

endmodule
